>>> rtl/utcl_pkg.sv
package utcl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADJ,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_WDAY,
        ST_YEARS,
        ST_MONTHS,
        ST_DECIDE,
        ST_DONE
    } utcl_state_t;

    // Standard-time calendar fields that the DST rule looks at.
    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [2:0] wday;
    } utcl_civil_t;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_IN_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] DAYS_PER_WEEK = 32'd7;

    // Adding one hour is done as subtracting its two's complement.
    localparam logic [31:0] NEG_HOUR = 32'd0 - SECS_IN_HOUR;

    // Restoring divisions: divisor preshifted to the top quotient bit.
    localparam logic [3:0]  CNT_DAY  = 4'd15;
    localparam logic [3:0]  CNT_HOUR = 4'd4;
    localparam logic [3:0]  CNT_MIN  = 4'd5;
    localparam logic [3:0]  CNT_WDAY = 4'd12;
    localparam logic [31:0] DV_DAY   = SECS_PER_DAY << CNT_DAY;
    localparam logic [31:0] DV_HOUR  = SECS_IN_HOUR << CNT_HOUR;
    localparam logic [31:0] DV_MIN   = SECS_PER_MIN << CNT_MIN;
    localparam logic [31:0] DV_WDAY  = DAYS_PER_WEEK << CNT_WDAY;

    // 1970-01-01 was a Thursday.
    localparam logic [31:0] EPOCH_WDAY = 32'd4;

    localparam logic [11:0] YEAR_BASE        = 12'd1970;
    localparam logic [11:0] YEAR_SHORT_BLOCK = 12'd2098;
    localparam logic [11:0] YEAR_NO_LEAP     = 12'd2100;
    localparam logic [3:0]  MONTH_LAST_IDX   = 4'd11;

    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;

endpackage

>>> rtl/utcl_cmpsub.sv
module utcl_cmpsub (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] diff,
    output logic        ge
);

    logic [32:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[31:0];
    assign ge   = ~wide[32];

endmodule

>>> rtl/utcl_dst.sv
module utcl_dst (
    input  utcl_pkg::utcl_civil_t civil,
    input  logic                  region,
    output logic                  dst
);

    import utcl_pkg::*;

    function automatic logic [2:0] mod7(input logic [6:0] x);
        logic [15:0] p;
        logic [4:0]  q;
        logic [6:0]  r;
        p = 16'(x) * 16'd293;
        q = p[15:11];
        r = x - 7'(q) * 7'd7;
        return r[2:0];
    endfunction

    logic [2:0] w31;
    logic [2:0] w1;
    logic [4:0] sun_eu;
    logic [4:0] first_sun;
    logic [4:0] sun_us;
    logic       eu_start;
    logic       eu_end;
    logic       us_past;

    always_comb
    begin
        // Weekday of the 31st and of the 1st of the current month.
        w31       = mod7(7'(civil.wday) + 7'd66 - 7'(civil.day));
        w1        = mod7(7'(civil.wday) + 7'd36 - 7'(civil.day));
        sun_eu    = 5'd31 - 5'(w31);
        first_sun = (w1 == 3'd0) ? 5'd1 : 5'd8 - 5'(w1);
        sun_us    = (civil.month == MONTH_MAR) ? first_sun + 5'd7 : first_sun;

        eu_start = (civil.day > sun_eu) || (civil.day == sun_eu && civil.hour >= 5'd2);
        eu_end   = (civil.day > sun_eu) || (civil.day == sun_eu && civil.hour >= 5'd3);
        us_past  = (civil.day > sun_us) || (civil.day == sun_us && civil.hour >= 5'd2);

        if (!region)
        begin
            if (civil.month < MONTH_MAR || civil.month > MONTH_OCT)
                dst = 1'b0;
            else if (civil.month == MONTH_MAR)
                dst = eu_start;
            else if (civil.month == MONTH_OCT)
                dst = ~eu_end;
            else
                dst = 1'b1;
        end
        else
        begin
            if (civil.month < MONTH_MAR || civil.month > MONTH_NOV)
                dst = 1'b0;
            else if (civil.month == MONTH_MAR)
                dst = us_past;
            else if (civil.month == MONTH_NOV)
                dst = ~us_past;
            else
                dst = 1'b1;
        end
    end

endmodule

>>> rtl/utc_to_local_time_with_dst_top.sv
// Converts Unix UTC seconds into local civil time for a whole-hour standard
// offset, applying the European or North American daylight saving rule, and
// returns year, month, day, hour, minute, second, weekday and a DST flag.
// One request is worked on at a time; in_stall stays high until its result
// has been placed in the output register, and the next request may be taken
// while that result still waits on out_stall. Everything runs through one
// 32-bit compare-and-subtract unit under a sequencer. One pass takes an
// offset step, the divisions (day, hour, minute, weekday), a year walk
// (four-year blocks, then single years), a month walk and a decision step.
// When the DST hour applies a second pass follows, and the result is then
// handed over to the output register.
module utc_to_local_time_with_dst_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] utc_seconds,
    input  logic signed [4:0] base_offset_hours,
    input  logic        dst_region,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] local_year,
    output logic [3:0]  local_month,
    output logic [4:0]  local_day,
    output logic [4:0]  local_hour,
    output logic [5:0]  local_minute,
    output logic [5:0]  local_second,
    output logic [2:0]  day_of_week,
    output logic        dst_active
);

    import utcl_pkg::*;

    function automatic logic leap_year(input logic [11:0] y);
        return (y[1:0] == 2'd0) && (y != YEAR_NO_LEAP);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (idx == 4'd1)
            len = leap ? 5'd29 : 5'd28;
        else if (idx inside {4'd3, 4'd5, 4'd8, 4'd10})
            len = 5'd30;
        return len;
    endfunction

    utcl_state_t state_reg, state_next;
    logic        pass_reg, pass_next;
    logic        dst_reg, dst_next;
    logic        out_valid_reg, out_valid_next;
    logic        blkfail_reg, blkfail_next;

    logic [31:0] utc_reg;
    logic [31:0] negoff_reg;
    logic        region_reg;
    logic [31:0] local_reg, local_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dv_reg, dv_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [2:0]  wday_reg, wday_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;

    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_minute_reg;
    logic [5:0]  out_second_reg;
    logic [2:0]  out_wday_reg;
    logic        out_dst_reg;

    logic        accept;
    logic        load_out;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] diff;
    logic        ge;
    logic [31:0] rem_step;
    logic [15:0] quo_step;
    logic        blk;
    logic        dst_now;
    logic [31:0] off_ext;
    utcl_civil_t civil;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign off_ext  = {{27{base_offset_hours[4]}}, base_offset_hours};
    assign blk      = (year_reg[1:0] == 2'd2) && !blkfail_reg;
    assign rem_step = ge ? diff : rem_reg;
    assign quo_step = {quo_reg[14:0], ge};

    assign civil.month = month_reg;
    assign civil.day   = day_reg;
    assign civil.hour  = hour_reg;
    assign civil.wday  = wday_reg;

    always_comb
    begin
        op_a = rem_reg;
        op_b = dv_reg;
        case (state_reg)
            ST_ADJ:
            begin
                op_a = pass_reg ? local_reg : utc_reg;
                op_b = pass_reg ? NEG_HOUR : negoff_reg;
            end
            ST_YEARS:
            begin
                if (blk)
                    op_b = (year_reg == YEAR_SHORT_BLOCK) ? 32'd1460 : 32'd1461;
                else
                    op_b = leap_year(year_reg) ? 32'd366 : 32'd365;
            end
            ST_MONTHS:
                op_b = 32'(month_days(month_reg, leap_year(year_reg)));
            default:
            begin
                op_a = rem_reg;
                op_b = dv_reg;
            end
        endcase
    end

    utcl_cmpsub u_cmpsub (
        .a    (op_a),
        .b    (op_b),
        .diff (diff),
        .ge   (ge)
    );

    utcl_dst u_dst (
        .civil  (civil),
        .region (region_reg),
        .dst    (dst_now)
    );

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        dst_next     = dst_reg;
        blkfail_next = blkfail_reg;
        local_next   = local_reg;
        rem_next     = rem_reg;
        dv_next      = dv_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        days_next    = days_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        wday_next    = wday_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        load_out     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pass_next  = 1'b0;
                    dst_next   = 1'b0;
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                local_next = diff;
                rem_next   = diff;
                dv_next    = DV_DAY;
                cnt_next   = CNT_DAY;
                state_next = ST_DAYS;
            end
            ST_DAYS, ST_HOURS, ST_MINS, ST_WDAY:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                dv_next  = dv_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    case (state_reg)
                        ST_DAYS:
                        begin
                            days_next  = quo_step;
                            dv_next    = DV_HOUR;
                            cnt_next   = CNT_HOUR;
                            state_next = ST_HOURS;
                        end
                        ST_HOURS:
                        begin
                            hour_next  = quo_step[4:0];
                            dv_next    = DV_MIN;
                            cnt_next   = CNT_MIN;
                            state_next = ST_MINS;
                        end
                        ST_MINS:
                        begin
                            minute_next = quo_step[5:0];
                            second_next = rem_step[5:0];
                            rem_next    = {16'd0, days_reg} + EPOCH_WDAY;
                            dv_next     = DV_WDAY;
                            cnt_next    = CNT_WDAY;
                            state_next  = ST_WDAY;
                        end
                        default:
                        begin
                            wday_next    = rem_step[2:0];
                            rem_next     = {16'd0, days_reg};
                            year_next    = YEAR_BASE;
                            blkfail_next = 1'b0;
                            state_next   = ST_YEARS;
                        end
                    endcase
                end
            end
            ST_YEARS:
            begin
                // Four-year blocks first while aligned, then single years.
                if (ge)
                begin
                    rem_next  = diff;
                    year_next = year_reg + (blk ? 12'd4 : 12'd1);
                end
                else if (blk)
                    blkfail_next = 1'b1;
                else
                begin
                    month_next = 4'd0;
                    state_next = ST_MONTHS;
                end
            end
            ST_MONTHS:
            begin
                if (ge && month_reg != MONTH_LAST_IDX)
                begin
                    rem_next   = diff;
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    day_next   = rem_reg[4:0] + 5'd1;
                    month_next = month_reg + 4'd1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // The rule is judged on standard time only.
                if (!pass_reg && dst_now)
                begin
                    dst_next   = 1'b1;
                    pass_next  = 1'b1;
                    state_next = ST_ADJ;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            dst_reg       <= 1'b0;
            blkfail_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            dst_reg       <= dst_next;
            blkfail_reg   <= blkfail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            utc_reg    <= utc_seconds;
            negoff_reg <= 32'd0 - off_ext * SECS_IN_HOUR;
            region_reg <= dst_region;
        end
        local_reg  <= local_next;
        rem_reg    <= rem_next;
        dv_reg     <= dv_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        if (load_out)
        begin
            out_year_reg   <= year_reg;
            out_month_reg  <= month_reg;
            out_day_reg    <= day_reg;
            out_hour_reg   <= hour_reg;
            out_minute_reg <= minute_reg;
            out_second_reg <= second_reg;
            out_wday_reg   <= wday_reg + 3'd1;
            out_dst_reg    <= dst_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign local_year   = out_year_reg;
    assign local_month  = out_month_reg;
    assign local_day    = out_day_reg;
    assign local_hour   = out_hour_reg;
    assign local_minute = out_minute_reg;
    assign local_second = out_second_reg;
    assign day_of_week  = out_wday_reg;
    assign dst_active   = out_dst_reg;

endmodule
